@@ rtl/tws_pkg.sv @@
// Package for the timing wheel scheduler: operation codes, field widths and
// the packed transfer types of the input and result channels.
// It has no dependencies.
package tws_pkg;

  localparam int ID_W       = 5;
  localparam int INTERVAL_W = 16;
  localparam int ID_LIMIT   = 2 ** ID_W;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]            op;
    logic [ID_W-1:0]       task_id;
    logic [INTERVAL_W-1:0] interval;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] fired_id;
    logic            last;
  } out_item_t;

endpackage

@@ rtl/tws_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// It has no dependencies.
module tws_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/tws_div.sv @@
// Divider by a constant that forms quotient and remainder by a reciprocal
// multiplication, registering product, quotient and remainder in turn, used
// to split a task period into whole turns and a slot offset. It has no dependencies.
module tws_div #(
  parameter int DIVISOR    = 16,
  parameter int DIVIDEND_W = 16,
  parameter int QUOT_W     = 12,
  parameter int REM_W      = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  output logic                  done,
  output logic [QUOT_W-1:0]     quot,
  output logic [REM_W-1:0]      rem
);

  localparam int SHIFT  = DIVIDEND_W + $clog2(DIVISOR);
  localparam int MULT_W = DIVIDEND_W + 2;
  localparam int PROD_W = DIVIDEND_W + MULT_W;
  localparam logic [MULT_W-1:0] MULT =
    MULT_W'(((64'd1 << SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR));

  logic                  st1_r, st2_r, st3_r;
  logic [DIVIDEND_W-1:0] dvd_r, dvd_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [QUOT_W-1:0]     quot_r, quot_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;

  always_comb begin
    dvd_nxt  = dvd_r;
    prod_nxt = prod_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    if (start) begin
      dvd_nxt  = dividend;
      prod_nxt = PROD_W'(dividend) * PROD_W'(MULT);
    end
    if (st1_r) begin
      quot_nxt = prod_r[SHIFT +: QUOT_W];
    end
    if (st2_r) begin
      rem_nxt = REM_W'(dvd_r - DIVIDEND_W'(quot_r) * DIVIDEND_W'(DIVISOR));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_r <= 1'b0;
      st2_r <= 1'b0;
      st3_r <= 1'b0;
    end else begin
      st1_r <= start;
      st2_r <= st1_r;
      st3_r <= st2_r;
    end
    dvd_r  <= dvd_nxt;
    prod_r <= prod_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = st3_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

@@ rtl/timing_wheel_scheduler.sv @@
// Timing wheel scheduler: a remove is done in S_IDLE; an add waits in S_DIV
// for the divider by a constant that splits the period into turns and slot.
// A tick scans the task table RAM, one entry per cycle while the result side
// does not stall a fired task, over min(MAX_TASKS, 32) entries.
// Reset clears the armed flags, the wheel index and the control state; the
// table RAM is not cleared. Depends on tws_pkg, tws_ram and tws_div.
module timing_wheel_scheduler #(
  parameter int WHEEL_SLOTS = 16,
  parameter int MAX_TASKS   = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tws_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tws_pkg::out_item_t out_data
);

  import tws_pkg::*;

  localparam int SLOT_W  = $clog2(WHEEL_SLOTS);
  localparam int ROUND_W = $clog2((2 ** INTERVAL_W - 2) / WHEEL_SLOTS + 1);
  localparam int ADDR_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int SCAN_N  = (MAX_TASKS < ID_LIMIT) ? MAX_TASKS : ID_LIMIT;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [ROUND_W-1:0] rounds;
    logic [ROUND_W-1:0] base_rounds;
    logic [SLOT_W-1:0]  offset;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [MAX_TASKS-1:0]  valid_r, valid_nxt;
  logic [SLOT_W-1:0]     wheel_r, wheel_nxt;
  logic [ADDR_W-1:0]     idx_r, idx_nxt;
  logic [ADDR_W-1:0]     add_addr_r, add_addr_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic [ID_W-1:0]       pend_id_r, pend_id_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic                  accept, id_ok, free, hit, fire, advance, scan_end;
  logic                  div_start, div_done;
  logic [ROUND_W-1:0]    div_quot;
  logic [SLOT_W-1:0]     div_rem;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr, rd_addr;
  entry_t                wr_entry, rd_entry;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] base,
                                                  input logic [SLOT_W-1:0] offset);
    logic [SLOT_W:0] sum;
    sum = {1'b0, base} + {1'b0, offset} + (SLOT_W + 1)'(1);
    if (sum >= (SLOT_W + 1)'(WHEEL_SLOTS)) begin
      sum = sum - (SLOT_W + 1)'(WHEEL_SLOTS);
    end
    return sum[SLOT_W-1:0];
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign id_ok     = 32'(in_data.task_id) < 32'(MAX_TASKS);
  assign div_start = accept && (in_data.op == OP_ADD) && id_ok && (in_data.interval != '0);
  assign free      = !out_valid_r || !out_stall;
  assign hit       = valid_r[idx_r] && (rd_entry.slot == wheel_r);
  assign fire      = hit && (rd_entry.rounds == '0);
  assign advance   = !(fire && pend_v_r && !free);
  assign scan_end  = (idx_r == ADDR_W'(SCAN_N - 1));

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    wheel_nxt     = wheel_r;
    idx_nxt       = idx_r;
    add_addr_nxt  = add_addr_r;
    pend_v_nxt    = pend_v_r;
    pend_id_nxt   = pend_id_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_entry      = rd_entry;
    rd_addr       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.op == OP_TICK) begin
            wheel_nxt = (wheel_r == SLOT_W'(WHEEL_SLOTS - 1)) ? '0 : wheel_r + SLOT_W'(1);
            idx_nxt   = '0;
            state_nxt = S_SCAN;
          end else if (div_start) begin
            add_addr_nxt = ADDR_W'(in_data.task_id);
            state_nxt    = S_DIV;
          end else if ((in_data.op == OP_REMOVE) && id_ok) begin
            valid_nxt[ADDR_W'(in_data.task_id)] = 1'b0;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          wr_en                = 1'b1;
          wr_addr              = add_addr_r;
          wr_entry.slot        = next_slot(wheel_r, div_rem);
          wr_entry.rounds      = div_quot;
          wr_entry.base_rounds = div_quot;
          wr_entry.offset      = div_rem;
          valid_nxt[add_addr_r] = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      S_SCAN: begin
        rd_addr = idx_r;
        if (advance) begin
          if (hit) begin
            wr_en = 1'b1;
            if (fire) begin
              wr_entry.slot   = next_slot(wheel_r, rd_entry.offset);
              wr_entry.rounds = rd_entry.base_rounds;
              if (pend_v_r) begin
                out_valid_nxt         = 1'b1;
                out_data_nxt.fired_id = pend_id_r;
                out_data_nxt.last     = 1'b0;
              end
              pend_v_nxt  = 1'b1;
              pend_id_nxt = ID_W'(idx_r);
            end else begin
              wr_entry.rounds = rd_entry.rounds - ROUND_W'(1);
            end
          end
          if (scan_end) begin
            idx_nxt   = '0;
            state_nxt = S_FLUSH;
          end else begin
            idx_nxt = idx_r + ADDR_W'(1);
            rd_addr = idx_nxt;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (free) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.fired_id = pend_id_r;
          out_data_nxt.last     = 1'b1;
          pend_v_nxt            = 1'b0;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      wheel_r     <= '0;
      idx_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      wheel_r     <= wheel_nxt;
      idx_r       <= idx_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    add_addr_r <= add_addr_nxt;
    pend_id_r  <= pend_id_nxt;
    out_data_r <= out_data_nxt;
  end

  tws_div #(
    .DIVISOR    (WHEEL_SLOTS),
    .DIVIDEND_W (INTERVAL_W),
    .QUOT_W     (ROUND_W),
    .REM_W      (SLOT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_data.interval - INTERVAL_W'(1)),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  tws_ram #(
    .WIDTH  ($bits(entry_t)),
    .DEPTH  (MAX_TASKS),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
